// File: rtl/run_length_byte_encoder_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef RUN_LENGTH_BYTE_ENCODER_UNIT_DEFINES_SVH
`define RUN_LENGTH_BYTE_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RLBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlbe same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RLBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlbe next-cycle check failed");

`endif

// File: rtl/rlbe_pkg.sv
`timescale 1ns / 1ps
package rlbe_pkg;

    // Item modes.
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_END  = 2'd1;
    localparam logic [1:0] MODE_PULL = 2'd2;

    // Segment limits and stream codes.
    localparam logic [6:0] MAX_SEG  = 7'd126;
    localparam logic [7:0] HDR_LIT  = 8'h80;
    localparam logic [7:0] TERM_BYTE = 8'hFF;

    // Buffer address width (256 entries).
    localparam int BUF_AW = 8;

    // One queued input word.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] mode;
    } t_item;

endpackage

// File: rtl/rlbe_front.sv
`timescale 1ns / 1ps
module rlbe_front import rlbe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);

    t_item      r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_fill;
    logic       w_put;
    logic       w_take;

    assign o_ready   = (r_fill != 2'd2);
    assign w_put     = i_valid && o_ready;
    assign o_q_valid = (r_fill != 2'd0);
    assign w_take    = i_q_pop && o_q_valid;
    assign o_q_item  = r_slot[r_rd];

    // Two-word queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_put) begin
                r_wr <= ~r_wr;
            end
            if (w_take) begin
                r_rd <= ~r_rd;
            end
            r_fill <= r_fill + {1'b0, w_put} - {1'b0, w_take};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_slot[r_wr] <= i_item;
        end
    end

endmodule

// File: rtl/rlbe_back.sv
`timescale 1ns / 1ps
module rlbe_back import rlbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_accepted,
    output logic       o_out_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_CMP  = 6'b000100,
        ST_EMIT = 6'b001000,
        ST_HEAD = 6'b010000,
        ST_HOUT = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1,
        PH_LIT  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ACT_READ = 2'd0,
        ACT_RUN  = 2'd1,
        ACT_LIT  = 2'd2,
        ACT_FAIL = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] val;
    } t_act;

    logic [7:0]        r_mem [256];
    logic [7:0]        r_rdata;
    t_state            r_state;
    t_phase            r_phase;
    logic [BUF_AW-1:0] r_rp;
    logic [BUF_AW:0]   r_cnt;
    logic [6:0]        r_seglen;
    logic [6:0]        r_left;
    logic              r_end;
    logic [6:0]        r_k;
    logic              r_run;
    logic [7:0]        r_b0;
    logic [7:0]        r_p1;
    logic [7:0]        r_p2;
    logic              r_e_val;
    logic [7:0]        r_e_byte;
    logic              r_ov;
    logic              r_acc;
    logic              r_val;
    logic [7:0]        r_byte;
    logic              r_last;

    logic              w_free;
    logic              w_closed;
    logic [BUF_AW-1:0] w_raddr;
    logic [BUF_AW:0]   w_consume;
    t_act              w_act;

    assign w_free   = !r_ov || i_ready;
    assign w_closed = r_end || r_cnt[BUF_AW];
    assign w_raddr  = r_rp + {1'b0, r_k};

    // Literal step at position t: stop, fetch the third byte, or give up.
    function automatic t_act eval_lit(input logic [6:0] t, input logic [8:0] n,
                                      input logic closed);
        t_act a;
        a.kind = ACT_FAIL;
        a.val  = t;
        if (t >= MAX_SEG || {2'b00, t} >= n) begin
            a.kind = ACT_LIT;
        end else if ({2'b00, t} + 9'd2 < n) begin
            a.kind = ACT_READ;
            a.val  = t + 7'd2;
        end else if (closed) begin
            a.kind = ACT_LIT;
            a.val  = (n >= {2'b00, MAX_SEG}) ? MAX_SEG : n[6:0];
        end
        return a;
    endfunction

    // Run step at length s: extend, close, or wait for more bytes.
    function automatic t_act eval_run(input logic [6:0] s, input logic [8:0] n,
                                      input logic closed);
        t_act a;
        a.kind = ACT_RUN;
        a.val  = s;
        if ({2'b00, s} < n && s < MAX_SEG) begin
            a.kind = ACT_READ;
        end else if (s < MAX_SEG && {2'b00, s} == n && !closed) begin
            a.kind = ACT_FAIL;
        end
        return a;
    endfunction

    // Scan decision for the byte that has just been read.
    always_comb begin
        w_act = '{kind: ACT_FAIL, val: 7'd0};
        if (r_k == 7'd0) begin
            if (r_cnt >= 9'd2) begin
                w_act = '{kind: ACT_READ, val: 7'd1};
            end else begin
                w_act = eval_lit(7'd0, r_cnt, w_closed);
            end
        end else if (r_k == 7'd1) begin
            if (r_p1 == r_rdata) begin
                w_act = eval_run(7'd2, r_cnt, w_closed);
            end else begin
                w_act = eval_lit(7'd0, r_cnt, w_closed);
            end
        end else if (r_run) begin
            if (r_rdata == r_b0) begin
                w_act = eval_run(r_k + 7'd1, r_cnt, w_closed);
            end else begin
                w_act = '{kind: ACT_RUN, val: r_k};
            end
        end else begin
            if (r_p1 == r_p2 && r_p2 == r_rdata) begin
                w_act = '{kind: ACT_LIT, val: r_k - 7'd2};
            end else begin
                w_act = eval_lit(r_k - 7'd1, r_cnt, w_closed);
            end
        end
    end

    // Bytes removed from the head by a segment byte.
    assign w_consume = (r_phase == PH_RUN) ? {2'b00, r_seglen} : 9'd1;

    // Dequeue whenever the idle sequencer starts an item.
    always_comb begin
        o_q_pop = 1'b0;
        if (r_state == ST_IDLE && i_q_valid) begin
            if (i_q_item.mode == MODE_PULL && (r_phase != PH_IDLE || r_cnt != 9'd0)) begin
                o_q_pop = 1'b1;
            end else begin
                o_q_pop = w_free;
            end
        end
    end

    // Sequencer, encoder state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_IDLE;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_seglen <= '0;
            r_left   <= '0;
            r_end    <= 1'b0;
            r_k      <= '0;
            r_run    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_k   <= '0;
                        r_run <= 1'b0;
                        if (i_q_item.mode == MODE_PULL && r_phase != PH_IDLE) begin
                            r_state <= ST_HEAD;
                        end else if (i_q_item.mode == MODE_PULL && r_cnt != 9'd0) begin
                            r_state <= ST_RD;
                        end else begin
                            r_ov   <= 1'b1;
                            r_acc  <= 1'b0;
                            r_val  <= 1'b0;
                            r_byte <= 8'd0;
                            r_last <= 1'b0;
                            case (i_q_item.mode)
                                MODE_PUSH: begin
                                    if (!r_end && !r_cnt[BUF_AW]) begin
                                        r_cnt <= r_cnt + 9'd1;
                                        r_acc <= 1'b1;
                                    end
                                end
                                MODE_END: begin
                                    if (!r_end) begin
                                        r_end <= 1'b1;
                                        r_acc <= 1'b1;
                                    end
                                end
                                MODE_PULL: begin
                                    if (r_end) begin
                                        r_val    <= 1'b1;
                                        r_byte   <= TERM_BYTE;
                                        r_last   <= 1'b1;
                                        r_end    <= 1'b0;
                                        r_rp     <= '0;
                                        r_cnt    <= '0;
                                        r_seglen <= '0;
                                        r_left   <= '0;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                ST_RD: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_k == 7'd0) begin
                        r_b0 <= r_rdata;
                        r_p1 <= r_rdata;
                    end else if (r_k == 7'd1) begin
                        r_p2  <= r_rdata;
                        r_run <= (r_p1 == r_rdata);
                    end else if (!r_run) begin
                        r_p1 <= r_p2;
                        r_p2 <= r_rdata;
                    end
                    case (w_act.kind)
                        ACT_READ: begin
                            r_k     <= w_act.val;
                            r_state <= ST_RD;
                        end
                        ACT_RUN: begin
                            r_phase  <= PH_RUN;
                            r_seglen <= w_act.val;
                            r_e_val  <= 1'b1;
                            r_e_byte <= {1'b0, w_act.val};
                            r_state  <= ST_EMIT;
                        end
                        ACT_LIT: begin
                            r_phase  <= PH_LIT;
                            r_seglen <= w_act.val;
                            r_left   <= w_act.val;
                            r_e_val  <= 1'b1;
                            r_e_byte <= HDR_LIT | {1'b0, w_act.val};
                            r_state  <= ST_EMIT;
                        end
                        default: begin
                            r_e_val  <= 1'b0;
                            r_e_byte <= 8'd0;
                            r_state  <= ST_EMIT;
                        end
                    endcase
                end
                ST_EMIT: begin
                    if (w_free) begin
                        r_ov    <= 1'b1;
                        r_acc   <= 1'b0;
                        r_val   <= r_e_val;
                        r_byte  <= r_e_byte;
                        r_last  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_HEAD: begin
                    r_state <= ST_HOUT;
                end
                ST_HOUT: begin
                    if (w_free) begin
                        r_ov    <= 1'b1;
                        r_acc   <= 1'b0;
                        r_val   <= 1'b1;
                        r_byte  <= r_rdata;
                        r_last  <= 1'b0;
                        r_rp    <= r_rp + w_consume[BUF_AW-1:0];
                        r_cnt   <= (r_cnt >= w_consume) ? r_cnt - w_consume : 9'd0;
                        r_state <= ST_IDLE;
                        if (r_phase == PH_RUN) begin
                            r_phase <= PH_IDLE;
                        end else begin
                            if (r_left > 7'd0) begin
                                r_left <= r_left - 7'd1;
                            end
                            if (r_left <= 7'd1) begin
                                r_phase <= PH_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Byte buffer: write on an accepted push, registered read at the scan address.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_q_pop && i_q_item.mode == MODE_PUSH
            && !r_end && !r_cnt[BUF_AW]) begin
            r_mem[r_rp + r_cnt[BUF_AW-1:0]] <= i_q_item.data;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_valid     = r_ov;
    assign o_accepted  = r_acc;
    assign o_out_valid = r_val;
    assign o_byte      = r_byte;
    assign o_last      = r_last;

endmodule

// File: rtl/run_length_byte_encoder_unit.sv
// Push, end mark and empty pulls are written to the output register as they leave the queue.
// A pull inside a segment passes through ST_HEAD (buffer read), then ST_HOUT (output).
// A pull that opens a segment scans the buffer byte by byte, each byte through ST_RD and ST_CMP.
// Throughput: one push or end mark per cycle while the output is free to take a word.
// Reset: synchronous, active low; clears control state, the buffer contents stay undefined.
`timescale 1ns / 1ps
module run_length_byte_encoder_unit import rlbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] accepted, [1] out_valid
    output logic       m_axis_tlast    // out_last
);

    t_item w_in;
    t_item w_q_item;
    logic  w_q_valid;
    logic  w_q_pop;

    assign w_in.mode = s_axis_tuser;
    assign w_in.data = s_axis_tdata;

    // Front queue decouples input acceptance from the sequencer.
    rlbe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    // Back end: buffer, segment scan and output register.
    rlbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_accepted  (m_axis_tuser[0]),
        .o_out_valid (m_axis_tuser[1]),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

// File: rtl/rlbe_checker.sv
`timescale 1ns / 1ps
`include "run_length_byte_encoder_unit_defines.svh"
module rlbe_checker import rlbe_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic w_acc;
    logic w_out;
    logic w_term_ok;
    logic w_quiet;
    logic w_stall;

    // Named views of the result word.
    assign w_acc     = m_axis_tuser[0];
    assign w_out     = m_axis_tuser[1];
    assign w_term_ok = w_out && (m_axis_tdata == TERM_BYTE);
    assign w_quiet   = (m_axis_tdata == 8'd0) && !m_axis_tlast;
    assign w_stall   = m_axis_tvalid && !m_axis_tready;

    // A terminator word is a valid 0xFF byte.
    `RLBE_ASSERT_NOW(a_term, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, w_term_ok)

    // A word never both acknowledges a push and carries a byte.
    `RLBE_ASSERT_NOW(a_excl, i_clk, i_rst_n, m_axis_tvalid, !(w_acc && w_out))

    // Without a byte the data field is zero.
    `RLBE_ASSERT_NOW(a_zero, i_clk, i_rst_n, m_axis_tvalid && !w_out, w_quiet)

    // A stalled word holds.
    `RLBE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind run_length_byte_encoder_unit rlbe_checker u_rlbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/run_length_byte_encoder_unit_tb.sv
`timescale 1ns / 1ps
module run_length_byte_encoder_unit_tb;
    import rlbe_pkg::*;

    localparam int BUF_DEPTH = 256;
    localparam int SEG_MAX = int'(MAX_SEG);
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Segment phases of the encoder model.
    typedef enum logic [1:0] {
        SEG_IDLE,
        SEG_RUN,
        SEG_LIT
    } t_seg_phase;

    // One result word as the encoder should return it.
    typedef struct {
        logic       accepted;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
    } t_enc_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] data_byte
    logic [1:0] s_axis_tuser;   // [1:0] mode
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic [1:0] m_axis_tuser;   // [0] accepted, [1] out_valid
    logic       m_axis_tlast;

    // Encoder model state.
    logic [7:0] queued_bytes [BUF_DEPTH];
    int         head_pos;
    int         queued_count;
    t_seg_phase seg_phase;
    int         seg_length;
    int         lit_left;
    int         head_streak;
    bit         block_closed;
    bit         saw_terminator;

    t_enc_result pending_results[$];
    int          fail_count;
    int          items_sent;
    int          cycle_count;

    run_length_byte_encoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [7:0] head_byte(int k);
        return queued_bytes[(head_pos + k) % BUF_DEPTH];
    endfunction

    function automatic void drop_head(int k);
        head_pos = (head_pos + k) % BUF_DEPTH;
        queued_count = (queued_count >= k) ? queued_count - k : 0;
    endfunction

    // Greedy choice of the next segment; returns 0 when it cannot be fixed yet.
    function automatic bit open_segment(output logic [7:0] header);
        int n;
        int s;
        int t;
        bit closed;
        n = queued_count;
        closed = block_closed || n >= BUF_DEPTH;
        header = 8'h00;
        if (n >= 2 && head_byte(0) == head_byte(1)) begin
            s = 2;
            while (s < n && s < SEG_MAX && head_byte(s) == head_byte(0))
                s++;
            head_streak = s;
            if (s < SEG_MAX && s == n && !closed)
                return 1'b0;
            seg_length = s;
            seg_phase = SEG_RUN;
            header = 8'(s);
            return 1'b1;
        end
        if (n == 0 || (n < 2 && !closed))
            return 1'b0;
        head_streak = 1;
        t = 0;
        // A literal stops before three equal bytes, at the limit or at the end.
        while (t < SEG_MAX && t < n) begin
            if (t + 2 < n) begin
                if (head_byte(t) == head_byte(t + 1) && head_byte(t) == head_byte(t + 2))
                    break;
                t++;
            end else if (closed) begin
                t++;
            end else begin
                return 1'b0;
            end
        end
        seg_length = t;
        lit_left = t;
        seg_phase = SEG_LIT;
        header = HDR_LIT | 8'(t);
        return 1'b1;
    endfunction

    // Works out the result word that one accepted item causes.
    function automatic t_enc_result encode_step(logic [1:0] mode, logic [7:0] data);
        t_enc_result r;
        logic [7:0] header;
        r = '{1'b0, 1'b0, 8'h00, 1'b0};
        saw_terminator = 1'b0;
        case (mode)
            MODE_PUSH: begin
                if (!block_closed && queued_count < BUF_DEPTH) begin
                    queued_bytes[(head_pos + queued_count) % BUF_DEPTH] = data;
                    queued_count++;
                    r.accepted = 1'b1;
                end
            end
            MODE_END: begin
                if (!block_closed) begin
                    block_closed = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            MODE_PULL: begin
                if (seg_phase == SEG_RUN) begin
                    r.out_byte = head_byte(0);
                    r.out_valid = 1'b1;
                    drop_head(seg_length);
                    seg_phase = SEG_IDLE;
                end else if (seg_phase == SEG_LIT) begin
                    r.out_byte = head_byte(0);
                    r.out_valid = 1'b1;
                    drop_head(1);
                    if (lit_left > 0)
                        lit_left--;
                    if (lit_left == 0)
                        seg_phase = SEG_IDLE;
                end else if (queued_count == 0) begin
                    if (block_closed) begin
                        r.out_byte = TERM_BYTE;
                        r.out_valid = 1'b1;
                        r.out_last = 1'b1;
                        block_closed = 1'b0;
                        head_pos = 0;
                        seg_length = 0;
                        lit_left = 0;
                        head_streak = 0;
                        saw_terminator = 1'b1;
                    end
                end else if (open_segment(header)) begin
                    r.out_byte = header;
                    r.out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Sends one word after a random gap and records what it should produce.
    task automatic send_word(logic [1:0] mode, logic [7:0] data);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = mode;
        s_axis_tdata = data;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(encode_step(mode, data));
        items_sent++;
    endtask

    // Closes the block and pulls until the terminator comes out.
    task automatic drain_block();
        send_word(MODE_END, 8'($urandom));
        do send_word(MODE_PULL, 8'($urandom)); while (!saw_terminator);
    endtask

    // Result side: random stalls, each word checked against the oldest expectation.
    initial begin
        int gap;
        t_enc_result exp_r;
        m_axis_tready = 1'b0;
        forever begin
            gap = $urandom_range(0, 4);
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tuser[0] !== exp_r.accepted) begin
                    $error("accepted: expected %0d, got %0d", exp_r.accepted, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tuser[1] !== exp_r.out_valid) begin
                    $error("out_valid: expected %0d, got %0d", exp_r.out_valid,
                           m_axis_tuser[1]);
                    fail_count++;
                end
                if (m_axis_tdata !== exp_r.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", exp_r.out_byte, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_r.out_last) begin
                    $error("out_last: expected %0d, got %0d", exp_r.out_last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Empty pulls, the spare mode, a second end mark and a push after the end mark.
    task automatic test_empty_block();
        send_word(MODE_PULL, 8'h00);
        send_word(MODE_SPARE, 8'hFF);
        send_word(MODE_END, 8'h00);
        send_word(MODE_END, 8'h00);
        send_word(MODE_PUSH, 8'hAA);
        send_word(MODE_PULL, 8'hFF);
        send_word(MODE_PULL, 8'h00);
    endtask

    // A run, a literal ending before three equal bytes, and a one-byte tail.
    task automatic test_runs_and_literals();
        send_word(MODE_PUSH, 8'h00);
        send_word(MODE_PULL, 8'h00);
        send_word(MODE_PUSH, 8'h00);
        send_word(MODE_PULL, 8'h00);
        send_word(MODE_PUSH, 8'hFF);
        send_word(MODE_PUSH, 8'h01);
        send_word(MODE_PUSH, 8'h55);
        send_word(MODE_PUSH, 8'h55);
        send_word(MODE_PUSH, 8'h55);
        send_word(MODE_PUSH, 8'h80);
        drain_block();
    endtask

    // Fills the buffer: the next push is refused and the full buffer counts as closed.
    task automatic test_full_buffer();
        int k;
        for (k = 0; k < BUF_DEPTH + 1; k++)
            send_word(MODE_PUSH, (k < 140) ? 8'h3C : 8'(k));
        send_word(MODE_PULL, 8'h00);
        send_word(MODE_PULL, 8'h00);
        drain_block();
    endtask

    // Random blocks, mostly well formed, with stray pulls, spare modes and early ends.
    task automatic test_random_blocks();
        int len;
        int k;
        int pick;
        logic [7:0] b;
        while (items_sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 270)
                                               : $urandom_range(0, 24);
            pick = $urandom_range(0, 1);
            b = 8'($urandom);
            for (k = 0; k < len; k++) begin
                // Small alphabets or sticky bytes give runs; otherwise full range.
                if ($urandom_range(0, 2) != 0)
                    b = pick ? 8'($urandom_range(0, 3)) : 8'($urandom);
                send_word(MODE_PUSH, b);
                case ($urandom_range(0, 29))
                    0, 1, 2, 3, 4: send_word(MODE_PULL, 8'($urandom));
                    5: send_word(MODE_SPARE, 8'($urandom));
                    6: send_word(MODE_END, 8'($urandom));
                    default: begin
                    end
                endcase
            end
            drain_block();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = MODE_PUSH;
        cycle_count = 0;
        fail_count = 0;
        items_sent = 0;
        head_pos = 0;
        queued_count = 0;
        seg_phase = SEG_IDLE;
        seg_length = 0;
        lit_left = 0;
        head_streak = 0;
        block_closed = 1'b0;
        saw_terminator = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_block();
        test_runs_and_literals();
        test_full_buffer();
        test_random_blocks();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/rlbe_pkg.sv
rtl/rlbe_front.sv
rtl/rlbe_back.sv
rtl/run_length_byte_encoder_unit.sv
rtl/rlbe_checker.sv
tb/sv/run_length_byte_encoder_unit_tb.sv
